@@ rtl/lbsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsp_pkg
// Shared types and constants of the liveness buffer slot planner.
// ----------------------------------------------------------------------------
package lbsp_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
	localparam int OUT_IDX_W = 6;

	localparam logic KIND_PINNED = 1'b0;
	localparam logic KIND_TEMP   = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	localparam logic [15:0] NEVER_FREE = 16'hFFFF;

	typedef struct packed {
		logic        kind;
		logic [31:0] size_bytes;
		logic [15:0] producer_node;
		logic [15:0] last_use_node;
	} req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] slot_index;
		logic                 fresh_slot;
		logic                 status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] size;
		logic        pinned;
		logic [15:0] free_after;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef logic [SLOT_W-1:0]  slot_idx_t;
	typedef logic [COUNT_W-1:0] slot_cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic rd_en;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_needed;
		logic last_read;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/liveness_buffer_slot_planner_top.sv @@
// ----------------------------------------------------------------------------
// liveness_buffer_slot_planner_top
// Best-fit buffer slot planner with liveness-based reuse of temporary slots.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------
//   req     | in  | req_valid / req_stall  | kind, size_bytes, nodes
//   rsp     | out | rsp_valid / rsp_stall  | slot_index, fresh_slot, status
//
// A temporary request with opened slots reads the slot table one slot per
// cycle, compares the last read data in the drain state, then commits, which
// registers its response; the next request is taken once the controller is
// idle again. A pinned request or an empty table goes straight to the commit.
// Reset clears the slot count but not the slot table; no clearing pass is run.
// The response register lets the next request be accepted while a response
// is stalled; the commit waits until that register is free.
// ----------------------------------------------------------------------------
module liveness_buffer_slot_planner_top import lbsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	lbsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbsp_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a request is in work");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
		else $error("response one cycle after accept");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid || !rsp_stall))
		else $error("commit overwrote a stalled response");

	a_fresh_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fresh_slot |-> rsp.status == STATUS_OK)
		else $error("fresh slot reported with capacity error");

endmodule

@@ rtl/lbsp_ram.sv @@
// ----------------------------------------------------------------------------
// lbsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/lbsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbsp_ctrl
// Sequencer: accept a request, sweep the slot table if needed, then commit the result.
// ----------------------------------------------------------------------------
module lbsp_ctrl import lbsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.scan_needed ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.last_read) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read data is compared in this cycle
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/lbsp_dpath.sv @@
// ----------------------------------------------------------------------------
// lbsp_dpath
// Request registers, slot table, best-fit comparator and response register.
// ----------------------------------------------------------------------------
module lbsp_dpath import lbsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_sts_t  sts,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp
);

	req_t        req_q;
	slot_idx_t   cnt_q;
	slot_idx_t   cmp_idx_q;
	logic        cmp_valid_q;
	logic        found_q;
	slot_idx_t   best_q;
	logic [31:0] best_size_q;
	slot_cnt_t   slots_used_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic             we;
	slot_idx_t        waddr;
	slot_entry_t      wentry;
	logic [ENTRY_W-1:0] rdata;
	slot_entry_t      rentry;
	logic             better;
	logic             full;
	logic             reuse;
	rsp_t             rsp_d;

	lbsp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (cmd.rd_en),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	assign rentry = slot_entry_t'(rdata);
	assign full   = (slots_used_q == COUNT_W'(MAX_SLOTS));
	assign reuse  = (req_q.kind == KIND_TEMP) && found_q;

	// strict less-than keeps the lower slot on equal sizes
	assign better = !rentry.pinned
		&& (rentry.free_after < req_q.producer_node)
		&& (rentry.size >= req_q.size_bytes)
		&& (!found_q || (rentry.size < best_size_q));

	assign sts.scan_needed = (req.kind == KIND_TEMP) && (slots_used_q != '0);
	assign sts.last_read   = ((COUNT_W'(cnt_q) + COUNT_W'(1)) == slots_used_q);
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	always_comb begin
		we     = 1'b0;
		waddr  = SLOT_W'(slots_used_q);
		wentry = '0;
		rsp_d  = '0;
		if (reuse) begin
			waddr             = best_q;
			wentry.size       = best_size_q;
			wentry.pinned     = 1'b0;
			wentry.free_after = req_q.last_use_node;
			rsp_d.slot_index  = OUT_IDX_W'(best_q);
			rsp_d.fresh_slot  = 1'b0;
			rsp_d.status      = STATUS_OK;
			we                = cmd.commit;
		end else if (full) begin
			rsp_d.status = STATUS_FULL;
		end else begin
			wentry.size       = req_q.size_bytes;
			wentry.pinned     = (req_q.kind == KIND_PINNED);
			wentry.free_after = (req_q.kind == KIND_PINNED) ? NEVER_FREE
				: req_q.last_use_node;
			rsp_d.slot_index  = OUT_IDX_W'(slots_used_q);
			rsp_d.fresh_slot  = 1'b1;
			rsp_d.status      = STATUS_OK;
			we                = cmd.commit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			slots_used_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			cmp_valid_q <= cmd.rd_en;
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (cmp_valid_q && better) begin
				found_q <= 1'b1;
			end
			if (cmd.commit && !reuse && !full) begin
				slots_used_q <= slots_used_q + COUNT_W'(1);
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
			cnt_q <= '0;
		end else if (cmd.rd_en) begin
			cnt_q <= cnt_q + SLOT_W'(1);
		end
		if (cmd.rd_en) begin
			cmp_idx_q <= cnt_q;
		end
		if (cmp_valid_q && better) begin
			best_q      <= cmp_idx_q;
			best_size_q <= rentry.size;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the liveness buffer slot planner. A table of
// directed requests walks pinned values, best-fit reuse, ties and a full slot
// table. Random, mostly well-formed temporaries follow. A model of the slot
// table predicts each response that no directed row gives, and each response
// is checked field by field in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import lbsp_pkg::*;

	localparam int RANDOM_REQUESTS = 1500;
	localparam int STALL_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = MAX_SLOTS + 16;
	localparam int DIRECTED_ROWS   = 17;

	typedef struct {
		req_t        request;
		logic [31:0] size_step;
		int          repeats;
		bit          typed;
		rsp_t        answer;
	} plan_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [31:0] slot_bytes [MAX_SLOTS];
	logic [15:0] slot_free_node [MAX_SLOTS];
	bit          slot_is_pinned [MAX_SLOTS];
	int          open_slots = 0;

	rsp_t      pending_slots [$];
	int        errors         = 0;
	int        quiet_cycles   = 0;
	int        send_idle_pct  = 13;
	int        recv_stall_pct = 54;
	int        node_clock     = 2200;
	plan_row_t plan_rows [DIRECTED_ROWS];

	liveness_buffer_slot_planner_top dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Best fit among free temporaries, else open a new slot, or report full.
	function automatic rsp_t plan_slot(input req_t r);
		rsp_t res;
		int   best;
		res  = '0;
		best = -1;
		if (r.kind == KIND_TEMP) begin
			for (int s = 0; s < open_slots; s++) begin
				if (!slot_is_pinned[s] && slot_free_node[s] < r.producer_node &&
						slot_bytes[s] >= r.size_bytes &&
						(best < 0 || slot_bytes[s] < slot_bytes[best]))
					best = s;
			end
			if (best >= 0) begin
				slot_free_node[best] = r.last_use_node;
				res.slot_index       = OUT_IDX_W'(best);
				res.status           = STATUS_OK;
				return res;
			end
		end
		if (open_slots >= MAX_SLOTS) begin
			res.status = STATUS_FULL;
			return res;
		end
		slot_bytes[open_slots]     = r.size_bytes;
		slot_is_pinned[open_slots] = (r.kind == KIND_PINNED);
		slot_free_node[open_slots] = (r.kind == KIND_PINNED) ? NEVER_FREE : r.last_use_node;
		res.slot_index             = OUT_IDX_W'(open_slots);
		res.fresh_slot             = 1'b1;
		res.status                 = STATUS_OK;
		open_slots++;
		return res;
	endfunction

	function automatic logic [31:0] rand_bytes();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 32'd16 << $urandom_range(0, 5);
			6, 7: return 32'($urandom_range(1, 1000));
			8: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t next_request();
		req_t r;
		int   pick;
		pick         = $urandom_range(0, 99);
		r.size_bytes = rand_bytes();
		if (pick < 85) begin
			// advance producers in planning order, keep lifetimes short
			node_clock      += $urandom_range(0, 3);
			r.kind          = KIND_TEMP;
			r.producer_node = 16'(node_clock);
			r.last_use_node = 16'(node_clock + $urandom_range(0, 40));
		end else if (pick < 92) begin
			r.kind          = KIND_PINNED;
			r.size_bytes    = $urandom;
			r.producer_node = 16'($urandom);
			r.last_use_node = 16'($urandom);
		end else begin
			// out-of-order producer; last use already past so the slot stays reusable
			r.kind          = KIND_TEMP;
			r.producer_node = 16'($urandom);
			r.last_use_node = 16'($urandom_range(0, node_clock));
		end
		return r;
	endfunction

	task automatic put_request(input req_t r, input bit typed, input rsp_t answer);
		rsp_t due;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		due = plan_slot(r);
		pending_slots.push_back(typed ? answer : due);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_slots.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_slots.size() == 0) begin
				$display("%0t: response with nothing outstanding: %p", $time, rsp);
				errors++;
			end else begin
				want = pending_slots.pop_front();
				if (rsp.slot_index !== want.slot_index) begin
					$display("%0t: slot_index expected %0d got %0d",
						$time, want.slot_index, rsp.slot_index);
					errors++;
				end
				if (rsp.fresh_slot !== want.fresh_slot) begin
					$display("%0t: fresh_slot expected %0b got %0b",
						$time, want.fresh_slot, rsp.fresh_slot);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0b got %0b",
						$time, want.status, rsp.status);
					errors++;
				end
			end
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		req_t r;
		rsp_t no_answer;
		no_answer = '0;
		plan_rows = '{
			'{'{KIND_PINNED, 32'd0, 16'd0, 16'd0}, 32'd0, 1, 1'b1, '{6'd0, 1'b1, STATUS_OK}},
			'{'{KIND_PINNED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 32'd0, 1, 1'b1,
				'{6'd1, 1'b1, STATUS_OK}},
			'{'{KIND_TEMP, 32'd100, 16'd0, 16'd5}, 32'd0, 1, 1'b1, '{6'd2, 1'b1, STATUS_OK}},
			// producer equal to last use: not yet free
			'{'{KIND_TEMP, 32'd50, 16'd5, 16'd8}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd50, 16'd6, 16'd10}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd50, 16'd9, 16'd12}, 32'd0, 1, 1'b0, '0},
			// last use stored ahead of producer
			'{'{KIND_TEMP, 32'd100, 16'd11, 16'd3}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd100, 16'd4, 16'd20}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd50, 16'd13, 16'd14}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd50, 16'd13, 16'd40}, 32'd0, 1, 1'b0, '0},
			// two free slots of equal size: lower index wins
			'{'{KIND_TEMP, 32'd50, 16'd100, 16'd101}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'd0, 16'd200, 16'd300}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'hFFFF_FFFF, 16'hFFFF, 16'd0}, 32'd0, 1, 1'b0, '0},
			'{'{KIND_TEMP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 32'd0, 1, 1'b0, '0},
			// growing sizes fill the table and run one past it
			'{'{KIND_TEMP, 32'd16, 16'd1000, 16'd2000}, 32'd16, 62, 1'b0, '0},
			'{'{KIND_PINNED, 32'd1, 16'h1234, 16'hABCD}, 32'd0, 1, 1'b1,
				'{6'd0, 1'b0, STATUS_FULL}},
			'{'{KIND_TEMP, 32'd8, 16'd2001, 16'd2100}, 32'd0, 1, 1'b0, '0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan_rows[i]) begin
			r = plan_rows[i].request;
			for (int k = 0; k < plan_rows[i].repeats; k++) begin
				put_request(r, plan_rows[i].typed, plan_rows[i].answer);
				r.size_bytes += plan_rows[i].size_step;
			end
		end
		wait_drained();
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 3) begin
				wait_drained();
				send_idle_pct  = 54;
				recv_stall_pct = 13;
			end else if (n == 2 * RANDOM_REQUESTS / 3) begin
				wait_drained();
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			put_request(next_request(), 1'b0, no_answer);
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lbsp_pkg.sv
rtl/lbsp_ram.sv
rtl/lbsp_ctrl.sv
rtl/lbsp_dpath.sv
rtl/liveness_buffer_slot_planner_top.sv
bench/tb_top.sv
